// ----- hdl/sha256_stream_hasher_core_defines.svh -----
// Assertion macros shared by the hasher modules.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/shs_pkg.sv -----
`default_nettype none
package shs_pkg;
    // Item passed from the front end to the compression engine.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    localparam logic [31:0] HashInit [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundK [0:63] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] PosMask = 6'h3F;
    localparam logic [5:0] LenPos  = 6'd56;
endpackage
`default_nettype wire

// ----- hdl/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher.
// Input channel: one item per handshake (i_valid high, o_stall low) carries
// an optional message byte (i_has_byte) and an end mark (i_end_of_message).
// Output channel: on each end mark the eight digest words leave in order,
// word 0 first, o_last_word high on word 7; the receiver holds i_stall.
// A four-entry queue parts the input side from the compression engine.
// Each byte is packed into the block by the engine; the 64th byte of a block
// starts the rounds (one round per cycle of the shared round unit) and the
// feed-forward. An end mark adds padding, one or two compressions and the
// output of the eight digest words. The engine takes no new item while it
// compresses, pads or outputs the digest.
// Reset is synchronous: the hash restarts with the initial values, the
// byte count and queue clear and no output is valid.
// While the receiver stalls, the engine holds the current word and waits;
// the queue absorbs further items, then o_stall rises.
`default_nettype none
module sha256_stream_hasher_core
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    logic  w_qv, w_pop;
    t_item w_item;

    shs_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_byte, .i_has_byte,
        .i_end_of_message, .o_q_valid(w_qv), .o_q_item(w_item), .i_q_pop(w_pop)
    );

    shs_engine u_engine (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_item(w_item), .o_q_pop(w_pop),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule
`default_nettype wire

// ----- hdl/shs_front.sv -----
`default_nettype none
`include "sha256_stream_hasher_core_defines.svh"
module shs_front
    import shs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_message,
    output logic            o_q_valid,
    output t_item           o_q_item,
    input  wire logic       i_q_pop
);
    t_item                r_mem [0:QueueDepth-1];
    logic [QueueAw-1:0]   r_wp, r_rp;
    logic [QueueAw:0]     r_cnt;
    logic                 w_push;

    // Items with neither flag do nothing, so they are dropped here.
    assign o_stall   = (r_cnt == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
    assign w_push    = i_valid && !o_stall && (i_has_byte || i_end_of_message);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data_byte: i_data_byte, has_byte: i_has_byte,
                             end_of_message: i_end_of_message};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueueAw+1)'(w_push) - (QueueAw+1)'(i_q_pop);
        end
    end

    `SHC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_q_pop, o_q_valid)
    `SHC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= (QueueAw+1)'(QueueDepth))
    `SHC_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push, o_q_valid)
endmodule
`default_nettype wire

// ----- hdl/shs_engine.sv -----
`default_nettype none
`include "sha256_stream_hasher_core_defines.svh"
module shs_engine
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPad  = 3'd1;
    localparam logic [2:0] StLen  = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StFf   = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]  r_st;
    logic        r_fin;        // message end pending for this item
    logic        r_after_len;  // compression running on the length block
    logic        r_need_len;   // pad spilled into another block
    logic [63:0] r_cnt;
    logic [5:0]  r_pos;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oi;
    logic [31:0] r_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] r_w [0:15];
    logic        r_ov;
    logic [31:0] r_od;
    logic [2:0]  r_ox;
    logic        r_ol;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_s0, w_s1, w_wnew, w_t1, w_t2, w_cur, w_b1, w_b0, w_ch, w_maj;
    logic [31:0] w_put;
    logic [7:0]  w_pbyte;
    logic        w_out_free;

    // Message schedule: a sixteen-word shift line extended one word per round.
    assign w_s0  = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1  = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_cur = r_w[0];
    assign w_b1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_t1  = r_v[7] + w_b1 + w_ch + RoundK[r_rnd] + w_cur;
    assign w_b0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t2  = w_b0 + w_maj;

    // Byte placed into the block: message byte, pad marker or zero fill.
    always_comb begin
        w_pbyte = 8'h00;
        if (r_st == StIdle) w_pbyte = i_q_item.data_byte;
        else if (r_st == StPad && r_fin) w_pbyte = PadByte;
        w_put = (r_pos[1:0] == 2'd0) ? 32'h0 : r_w[r_pos[5:2]];
        w_put = w_put | (32'(w_pbyte) << ((3 - int'(r_pos[1:0])) * 8));
    end

    assign w_out_free = !r_ov || !i_stall;
    assign o_q_pop = (r_st == StIdle) && i_q_valid;
    assign o_valid = r_ov;
    assign o_digest_word = r_od;
    assign o_word_index  = r_ox;
    assign o_last_word   = r_ol;

    // Sequencer for packing, padding, length, rounds, feed-forward and digest output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_cnt <= '0;
            r_pos <= '0;
            r_ov <= 1'b0;
            r_fin <= 1'b0;
            r_after_len <= 1'b0;
            r_need_len <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= HashInit[i];
        end else begin
            // The output state refills the word itself once it is taken.
            if (r_ov && !i_stall && r_st != StOut) r_ov <= 1'b0;
            unique case (r_st)
                StIdle: begin
                    if (i_q_valid) begin
                        r_fin <= i_q_item.end_of_message;
                        r_after_len <= 1'b0;
                        if (i_q_item.has_byte) begin
                            r_w[r_pos[5:2]] <= w_put;
                            r_cnt <= r_cnt + 64'd1;
                            r_pos <= r_pos + 6'd1;
                            if (r_pos == PosMask) begin
                                r_st <= StRnd;
                                r_rnd <= '0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end else if (i_q_item.end_of_message) begin
                                r_st <= StPad;
                            end
                        end else begin
                            r_st <= StPad;
                        end
                    end
                end
                StPad: begin
                    // The pad marker is written while r_fin is set, zero fill after it.
                    r_w[r_pos[5:2]] <= w_put;
                    r_pos <= r_pos + 6'd1;
                    r_fin <= 1'b0;
                    if (r_pos == PosMask) begin
                        r_need_len <= 1'b1;
                        r_st <= StRnd;
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else if (r_pos == LenPos - 6'd1) begin
                        r_st <= StLen;
                    end
                end
                StLen: begin
                    r_w[14] <= r_cnt[60:29];
                    r_w[15] <= {r_cnt[28:0], 3'b000};
                    r_pos <= '0;
                    r_after_len <= 1'b1;
                    r_st <= StRnd;
                    r_rnd <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                StRnd: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wnew;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_st <= StFf;
                end
                StFf: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (r_after_len) begin
                        r_st <= StOut;
                        r_oi <= '0;
                    end else if (r_fin || r_need_len) begin
                        // Message end after a full block, or pad spilled over.
                        r_need_len <= 1'b0;
                        r_st <= StPad;
                    end else begin
                        r_st <= StIdle;
                    end
                end
                StOut: begin
                    if (w_out_free) begin
                        r_ov <= 1'b1;
                        r_od <= r_h[r_oi];
                        r_ox <= r_oi;
                        r_ol <= (r_oi == 3'd7);
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_st <= StIdle;
                            r_cnt <= '0;
                            r_pos <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= HashInit[i];
                        end
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    `SHC_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_st == StIdle)
    `SHC_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n,
        r_st == StOut && w_out_free && r_oi == 3'd7, r_st == StIdle && r_ol)
    `SHC_ASSERT_IMP(a_pos_len, i_clk, i_rst_n, r_st == StLen, r_pos == LenPos)
endmodule
`default_nettype wire
